>>> rtl/cscmv_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sparse column matvec accumulate core
// no dependencies

package cscmv_pkg;

   localparam int ROWS = 64;
   localparam int COLS = 64;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int DATA_W = 32;
   localparam int IDX_W = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA = 1'b1;

   localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
   localparam logic [DATA_W-1:0] BETA_RESET = 32'h0000_0000;

   typedef enum logic [1:0] {
      OP_LOAD_Y = 2'd0,
      OP_LOAD_X = 2'd1,
      OP_ACCUM  = 2'd2,
      OP_READ_Y = 2'd3
   } op_type;

   typedef struct packed {
      op_type opcode;
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [IDX_W-1:0] read_row;
      logic saturated;
   } rsp_type;

   typedef struct packed {
      logic mul_en;
      logic signed [DATA_W-1:0] mul_a;
      logic signed [DATA_W-1:0] mul_b;
      logic signed [DATA_W-1:0] add_y;
   } mac_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prod_q;
      logic prod_sat;
      logic signed [DATA_W-1:0] sum_q;
      logic sum_sat;
   } mac_sts_type;

endpackage

>>> rtl/cscmv_ram.sv
`timescale 1ns / 1ps
// generic single write, single read memory with registered read data
// no dependencies

module cscmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cscmv_mac.sv
`timescale 1ns / 1ps
// shared q16.16 multiplier with registered product, floor shift, saturation and add
// depends on cscmv_pkg

module cscmv_mac (
   input  logic clock,
   input  cscmv_pkg::mac_ctl_type ctl,
   output cscmv_pkg::mac_sts_type sts
);

   logic signed [2*cscmv_pkg::DATA_W-1:0] prod_ff;
   logic signed [2*cscmv_pkg::DATA_W-1:0] prod_in;
   logic signed [cscmv_pkg::DATA_W:0] sum_wide;
   logic [16:0] hi_bits;
   logic all_ones;
   logic all_zeros;

   assign prod_in = ctl.mul_a * ctl.mul_b;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // floor shift by 16 keeps bits 47:16; bits 63:47 must agree
   always_comb begin
      hi_bits = prod_ff[63:47];
      all_ones = &hi_bits[16:0];
      all_zeros = ~|hi_bits[16:0];
      sts.prod_sat = !(all_ones || all_zeros);
      if (all_ones || all_zeros) begin
         sts.prod_q = prod_ff[47:16];
      end else if (prod_ff[63]) begin
         sts.prod_q = {1'b1, {(cscmv_pkg::DATA_W-1){1'b0}}};
      end else begin
         sts.prod_q = {1'b0, {(cscmv_pkg::DATA_W-1){1'b1}}};
      end

      sum_wide = {ctl.add_y[cscmv_pkg::DATA_W-1], ctl.add_y}
               + {sts.prod_q[cscmv_pkg::DATA_W-1], sts.prod_q};
      sts.sum_sat = sum_wide[cscmv_pkg::DATA_W] != sum_wide[cscmv_pkg::DATA_W-1];
      if (!sts.sum_sat) begin
         sts.sum_q = sum_wide[cscmv_pkg::DATA_W-1:0];
      end else if (sum_wide[cscmv_pkg::DATA_W]) begin
         sts.sum_q = {1'b1, {(cscmv_pkg::DATA_W-1){1'b0}}};
      end else begin
         sts.sum_q = {1'b0, {(cscmv_pkg::DATA_W-1){1'b1}}};
      end
   end

endmodule

>>> rtl/sparse_csc_matvec_accumulate_core.sv
`timescale 1ns / 1ps
// top level: y = alpha*A*x + beta*y over streamed nonzeros, q16.16
// depends on cscmv_pkg, cscmv_ram, cscmv_mac
//
//   channel  | ports                         | direction | beat
//   request  | req_valid req_stall req_payload | in      | opcode, row, col, value
//   response | rsp_valid rsp_stall rsp_payload | out     | read value, row, sat flag
//   csr      | csr_wr_en csr_index csr_wr_data | in      | alpha, beta gains
//
// load x: written on accept; load y: S_LDY; read y: S_RD, held by any output stall;
// nonzero: S_NZ1, S_NZ2, S_NZ3, as the shared multiplier is used twice and y is read
// and written. req_stall is high while an item is in work. y and x memories need no
// clearing; reset clears control and the sat flag, sets alpha to 1.0 and beta to 0.
// The response register holds a beat under rsp_stall while the next items are taken.

module sparse_csc_matvec_accumulate_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  cscmv_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output cscmv_pkg::rsp_type rsp_payload,
   input  logic csr_wr_en,
   input  logic [cscmv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cscmv_pkg::DATA_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LDY,
      S_NZ1,
      S_NZ2,
      S_NZ3,
      S_RD
   } state_type;

   state_type state_ff;
   logic signed [cscmv_pkg::DATA_W-1:0] alpha_ff;
   logic signed [cscmv_pkg::DATA_W-1:0] beta_ff;
   logic signed [cscmv_pkg::DATA_W-1:0] a1_ff;
   logic [cscmv_pkg::ROW_AW-1:0] row_ff;
   logic [cscmv_pkg::IDX_W-1:0] echo_row_ff;
   logic rd_ok_ff;
   logic sat_seen_ff;
   logic rsp_valid_ff;
   cscmv_pkg::rsp_type rsp_ff;

   logic accept;
   logic row_ok;
   logic col_ok;
   logic xidx_ok;
   logic out_free;

   logic y_wr_en;
   logic [cscmv_pkg::ROW_AW-1:0] y_wr_addr;
   logic [cscmv_pkg::DATA_W-1:0] y_wr_data;
   logic y_rd_en;
   logic [cscmv_pkg::ROW_AW-1:0] y_rd_addr;
   logic [cscmv_pkg::DATA_W-1:0] y_rd_data;
   logic x_wr_en;
   logic x_rd_en;
   logic [cscmv_pkg::DATA_W-1:0] x_rd_data;

   cscmv_pkg::mac_ctl_type mac_ctl;
   cscmv_pkg::mac_sts_type mac_sts;

   assign req_stall = state_ff != S_IDLE;
   assign accept = req_valid && !req_stall;
   assign row_ok = 32'(req_payload.row_index) < cscmv_pkg::ROWS;
   assign xidx_ok = 32'(req_payload.row_index) < cscmv_pkg::COLS;
   assign col_ok = 32'(req_payload.col_index) < cscmv_pkg::COLS;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      x_wr_en = accept && req_payload.opcode == cscmv_pkg::OP_LOAD_X && xidx_ok;
      x_rd_en = accept && req_payload.opcode == cscmv_pkg::OP_ACCUM;

      y_rd_en = 1'b0;
      y_rd_addr = row_ff;
      if (accept && req_payload.opcode == cscmv_pkg::OP_READ_Y) begin
         y_rd_en = 1'b1;
         y_rd_addr = cscmv_pkg::ROW_AW'(req_payload.row_index);
      end else if (state_ff == S_NZ2) begin
         y_rd_en = 1'b1;
      end

      y_wr_en = state_ff == S_LDY || state_ff == S_NZ3;
      y_wr_addr = row_ff;
      y_wr_data = (state_ff == S_LDY) ? mac_sts.prod_q : mac_sts.sum_q;

      mac_ctl.mul_en = 1'b0;
      mac_ctl.mul_a = alpha_ff;
      mac_ctl.mul_b = req_payload.value;
      mac_ctl.add_y = y_rd_data;
      if (state_ff == S_IDLE) begin
         mac_ctl.mul_en = 1'b1;
         mac_ctl.mul_a = (req_payload.opcode == cscmv_pkg::OP_LOAD_Y) ? beta_ff : alpha_ff;
      end else if (state_ff == S_NZ2) begin
         mac_ctl.mul_en = 1'b1;
         mac_ctl.mul_a = a1_ff;
         mac_ctl.mul_b = x_rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         alpha_ff <= cscmv_pkg::ALPHA_RESET;
         beta_ff <= cscmv_pkg::BETA_RESET;
         sat_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               cscmv_pkg::CSR_ALPHA: alpha_ff <= csr_wr_data;
               cscmv_pkg::CSR_BETA:  beta_ff <= csr_wr_data;
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && state_ff != S_RD) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  row_ff <= cscmv_pkg::ROW_AW'(req_payload.row_index);
                  echo_row_ff <= req_payload.row_index;
                  rd_ok_ff <= row_ok;
                  unique case (req_payload.opcode)
                     cscmv_pkg::OP_LOAD_Y: if (row_ok) state_ff <= S_LDY;
                     cscmv_pkg::OP_LOAD_X: ;
                     cscmv_pkg::OP_ACCUM:  if (row_ok && col_ok) state_ff <= S_NZ1;
                     cscmv_pkg::OP_READ_Y: state_ff <= S_RD;
                     default: ;
                  endcase
               end
            end
            S_LDY: begin
               if (mac_sts.prod_sat) sat_seen_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_NZ1: begin
               a1_ff <= mac_sts.prod_q;
               if (mac_sts.prod_sat) sat_seen_ff <= 1'b1;
               state_ff <= S_NZ2;
            end
            S_NZ2: begin
               state_ff <= S_NZ3;
            end
            S_NZ3: begin
               if (mac_sts.prod_sat || mac_sts.sum_sat) sat_seen_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_RD: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.read_value <= rd_ok_ff ? y_rd_data : '0;
                  rsp_ff.read_row <= echo_row_ff;
                  rsp_ff.saturated <= sat_seen_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   cscmv_ram #(
      .WIDTH(cscmv_pkg::DATA_W),
      .DEPTH(cscmv_pkg::ROWS)
   ) u_y_ram (
      .clock(clock),
      .wr_en(y_wr_en),
      .wr_addr(y_wr_addr),
      .wr_data(y_wr_data),
      .rd_en(y_rd_en),
      .rd_addr(y_rd_addr),
      .rd_data(y_rd_data)
   );

   cscmv_ram #(
      .WIDTH(cscmv_pkg::DATA_W),
      .DEPTH(cscmv_pkg::COLS)
   ) u_x_ram (
      .clock(clock),
      .wr_en(x_wr_en),
      .wr_addr(cscmv_pkg::COL_AW'(req_payload.row_index)),
      .wr_data(req_payload.value),
      .rd_en(x_rd_en),
      .rd_addr(cscmv_pkg::COL_AW'(req_payload.col_index)),
      .rd_data(x_rd_data)
   );

   cscmv_mac u_mac (
      .clock(clock),
      .ctl(mac_ctl),
      .sts(mac_sts)
   );

endmodule
